### rtl/cscc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cscc_pkg;
	localparam int MaxBoxes = 16;
	localparam int BoxIdxW = $clog2(MaxBoxes);
	localparam int BoxCntW = $clog2(MaxBoxes + 1);
	localparam int NumChan = 3;
	localparam int NumRegs = 6;
	localparam int RegIdxW = 3;
	localparam int BoxW = 48;
	localparam int NumW = 25;
	localparam int DenW = 17;
	localparam logic [7:0] LevelMax = 8'd255;

	typedef enum logic [RegIdxW-1:0] {
		REG_RED_LOW = 3'd0,
		REG_RED_HIGH = 3'd1,
		REG_GREEN_LOW = 3'd2,
		REG_GREEN_HIGH = 3'd3,
		REG_BLUE_LOW = 3'd4,
		REG_BLUE_HIGH = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} lane_ctl_t;
endpackage
`default_nettype wire

### rtl/cscc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module cscc_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(Depth)-1:0] waddr,
	input  wire [Width-1:0]         wdata,
	input  wire [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]        rdata
);
	logic [Width-1:0] mem [Depth];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### rtl/cscc_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// One channel: restoring signed division of (x-lo)*255 by (hi-lo), saturated.
module cscc_lane import cscc_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	input  wire [15:0] pulse,
	input  wire [15:0] cal_low,
	input  wire [15:0] cal_high,
	output lane_ctl_t  ctl,
	output logic [7:0] level
);
	logic [NumW-1:0] quo_q;
	logic [DenW-1:0] rem_q;
	logic [DenW-1:0] den_q;
	logic            neg_q;
	logic            zero_q;
	logic [4:0]      cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [7:0]      level_q;

	logic signed [16:0]     diff;
	logic signed [16:0]     dsig;
	logic signed [NumW-1:0] num;
	logic [NumW-1:0]        num_mag;
	logic [DenW-1:0]        den_mag;
	logic [DenW:0]          trial;
	logic [DenW-1:0]        rem_sh;

	always_comb begin
		diff = $signed({1'b0, pulse}) - $signed({1'b0, cal_low});
		dsig = $signed({1'b0, cal_high}) - $signed({1'b0, cal_low});
		num = $signed(NumW'(diff)) * $signed(NumW'(LevelMax));
		num_mag = num[NumW-1] ? NumW'(-num) : num;
		den_mag = dsig[16] ? DenW'(-dsig) : DenW'(dsig);
		rem_sh = {rem_q[DenW-2:0], quo_q[NumW-1]};
		trial = {1'b0, rem_sh} - {1'b0, den_q};
	end

	// iterate one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q <= 5'(NumW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			quo_q <= num_mag;
			rem_q <= '0;
			den_q <= den_mag;
			neg_q <= num[NumW-1] ^ dsig[16];
			zero_q <= (dsig == 17'sd0);
		end else if (busy_q) begin
			if (!trial[DenW]) begin
				rem_q <= trial[DenW-1:0];
				quo_q <= {quo_q[NumW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[NumW-2:0], 1'b0};
			end
		end
	end

	// saturate: negative quotient or zero divisor gives 0, above LevelMax gives LevelMax
	always_comb begin
		if (zero_q || neg_q) begin
			level_q = 8'd0;
		end else if (quo_q > NumW'(LevelMax)) begin
			level_q = LevelMax;
		end else begin
			level_q = quo_q[7:0];
		end
	end

	assign level = level_q;
	assign ctl = '{start: start, busy: busy_q, done: done_q};
endmodule
`default_nettype wire

### rtl/color_sensor_calibrate_classify.sv
`timescale 1ns / 1ps
`default_nettype none
// Append: start passes through an append state that raises the result strobe.
// Classify: three division lanes develop 25-bit quotients, then a scan of box_count
// table entries, each through a read state and a compare state, stops at the first hit.
// One item at a time; busy is high meanwhile and drops with the strobe.
// Reset clears box count and restores calibration defaults; table contents
// stay undefined and are never read beyond the count. Receiver cannot stall.
module color_sensor_calibrate_classify import cscc_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire         cfg_we,
	input  wire [2:0]   cfg_index,
	input  wire [15:0]  cfg_data,
	input  wire         mode,
	input  wire [15:0]  red_pulse,
	input  wire [15:0]  green_pulse,
	input  wire [15:0]  blue_pulse,
	input  wire [7:0]   red_low,
	input  wire [7:0]   red_high,
	input  wire [7:0]   green_low,
	input  wire [7:0]   green_high,
	input  wire [7:0]   blue_low,
	input  wire [7:0]   blue_high,
	output logic        strobe,
	output logic        found,
	output logic [3:0]  match_index,
	output logic [7:0]  red_level,
	output logic [7:0]  green_level,
	output logic [7:0]  blue_level,
	output logic        table_full
);
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_RD   = 5'b00100,
		ST_CMP  = 5'b01000,
		ST_APP  = 5'b10000
	} state_t;

	state_t state_q;
	logic [15:0] cal_q [NumRegs];
	logic [BoxCntW-1:0] count_q;
	logic [BoxCntW-1:0] scan_q;
	logic [7:0] lvl_q [NumChan];
	logic full_q;
	logic accept;
	logic div_start;
	lane_ctl_t ctl [NumChan];
	logic [7:0] lvl [NumChan];
	logic [15:0] pulse [NumChan];
	logic [BoxW-1:0] rdata;
	logic we;
	logic hit;

	assign accept = start && (state_q == ST_IDLE);
	assign div_start = accept && mode;
	assign pulse[0] = red_pulse;
	assign pulse[1] = green_pulse;
	assign pulse[2] = blue_pulse;
	assign we = accept && !mode && (count_q < BoxCntW'(MaxBoxes));

	// calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumRegs; i++) begin
				cal_q[i] <= i[0] ? 16'hffff : 16'h0000;
			end
		end else if (cfg_we && cfg_index <= REG_BLUE_HIGH) begin
			cal_q[cfg_index] <= cfg_data;
		end
	end

	// one division lane per channel
	for (genvar c = 0; c < NumChan; c++) begin : g_lane
		cscc_lane u_lane (
			.clk(clk), .arst_n(arst_n), .start(div_start), .pulse(pulse[c]),
			.cal_low(cal_q[2*c]), .cal_high(cal_q[2*c+1]),
			.ctl(ctl[c]), .level(lvl[c])
		);
	end

	cscc_ram #(.Width(BoxW), .Depth(MaxBoxes)) u_ram (
		.clk(clk), .we(we), .waddr(count_q[BoxIdxW-1:0]),
		.wdata({red_low, red_high, green_low, green_high, blue_low, blue_high}),
		.raddr(scan_q[BoxIdxW-1:0]), .rdata(rdata)
	);

	// merge: box containment over all channels
	assign hit = (lvl_q[0] >= rdata[47:40]) && (lvl_q[0] <= rdata[39:32]) &&
		(lvl_q[1] >= rdata[31:24]) && (lvl_q[1] <= rdata[23:16]) &&
		(lvl_q[2] >= rdata[15:8]) && (lvl_q[2] <= rdata[7:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			scan_q <= '0;
			strobe <= 1'b0;
			full_q <= 1'b0;
			found <= 1'b0;
			match_index <= '0;
			red_level <= '0;
			green_level <= '0;
			blue_level <= '0;
			table_full <= 1'b0;
			for (int c = 0; c < NumChan; c++) begin
				lvl_q[c] <= '0;
			end
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= mode ? ST_DIV : ST_APP;
						full_q <= !mode && !we;
						if (we) begin
							count_q <= count_q + BoxCntW'(1);
						end
					end
				end
				ST_APP: begin
					strobe <= 1'b1;
					found <= 1'b0;
					match_index <= '0;
					red_level <= '0;
					green_level <= '0;
					blue_level <= '0;
					table_full <= full_q;
					state_q <= ST_IDLE;
				end
				ST_DIV: begin
					if (ctl[0].done) begin
						for (int c = 0; c < NumChan; c++) begin
							lvl_q[c] <= lvl[c];
						end
						scan_q <= '0;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					if (scan_q >= count_q) begin
						strobe <= 1'b1;
						found <= 1'b0;
						match_index <= '0;
						red_level <= lvl_q[0];
						green_level <= lvl_q[1];
						blue_level <= lvl_q[2];
						table_full <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (hit) begin
						strobe <= 1'b1;
						found <= 1'b1;
						match_index <= 4'(scan_q);
						red_level <= lvl_q[0];
						green_level <= lvl_q[1];
						blue_level <= lvl_q[2];
						table_full <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						scan_q <= scan_q + BoxCntW'(1);
						state_q <= ST_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);

`ifndef ASSERT_OFF
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= BoxCntW'(MaxBoxes)) else $error("box count overflow");
	a_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		ctl[0].done == ctl[1].done && ctl[0].done == ctl[2].done)
		else $error("lanes out of step");
	a_str: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> state_q == ST_IDLE) else $error("strobe while busy");
	a_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP |-> scan_q < count_q) else $error("scan past count");
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		ctl[0].busy |-> state_q == ST_DIV) else $error("lane busy outside divide");
`endif
endmodule
`default_nettype wire

### bench/color_sensor_calibrate_classify_tb.sv
`timescale 1ns / 1ps
module color_sensor_calibrate_classify_tb;
	import cscc_pkg::*;

	localparam logic MODE_APPEND = 1'b0;
	localparam logic MODE_CLASSIFY = 1'b1;
	localparam int CycleLimit = 400000;

	typedef struct {
		logic        op;
		logic [15:0] pulse [3];
		logic [7:0]  lo [3];
		logic [7:0]  hi [3];
		logic        cfg;      // calibration update, applied when idle
		logic [15:0] cal [6];
	} sample_t;

	typedef struct {
		logic       found;
		logic [3:0] idx;
		logic [7:0] level [3];
		logic       full;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic mode = 1'b0;
	logic [15:0] red_pulse = '0, green_pulse = '0, blue_pulse = '0;
	logic [7:0] red_low = '0, red_high = '0, green_low = '0;
	logic [7:0] green_high = '0, blue_low = '0, blue_high = '0;
	logic strobe, found, table_full;
	logic [3:0] match_index;
	logic [7:0] red_level, green_level, blue_level;

	sample_t pending_q [$];
	verdict_t verdict_q [$];
	logic [15:0] cal_shadow [6];
	logic [7:0] box_lo [MaxBoxes][3];
	logic [7:0] box_hi [MaxBoxes][3];
	int box_total;
	int mismatches = 0;
	int cycles = 0;
	bit stim_done = 1'b0;
	bit calm = 1'b0;
	int cfg_step;
	int settle;

	color_sensor_calibrate_classify DUT (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	// Scale a pulse width to a saturated 0..255 level
	function automatic logic [7:0] scale_width(logic [15:0] x, logic [15:0] lo,
		logic [15:0] hi);
		int num, den, q;
		num = (int'(x) - int'(lo)) * 255;
		den = int'(hi) - int'(lo);
		if (den == 0) return 8'd0;
		q = num / den;
		if (q < 0) return 8'd0;
		if (q > 255) return 8'd255;
		return q[7:0];
	endfunction

	// Advance the table model and return the expected verdict
	function automatic verdict_t classify_or_append(sample_t s);
		verdict_t v;
		bit hit;
		v.found = 1'b0;
		v.idx = '0;
		v.full = 1'b0;
		for (int c = 0; c < 3; c++) v.level[c] = '0;
		if (s.op == MODE_APPEND) begin
			if (box_total >= MaxBoxes) begin
				v.full = 1'b1;
			end else begin
				for (int c = 0; c < 3; c++) begin
					box_lo[box_total][c] = s.lo[c];
					box_hi[box_total][c] = s.hi[c];
				end
				box_total++;
			end
			return v;
		end
		for (int c = 0; c < 3; c++)
			v.level[c] = scale_width(s.pulse[c], cal_shadow[2*c], cal_shadow[2*c+1]);
		for (int k = 0; k < box_total; k++) begin
			hit = 1'b1;
			for (int c = 0; c < 3; c++)
				if (v.level[c] < box_lo[k][c] || v.level[c] > box_hi[k][c]) hit = 1'b0;
			if (hit) begin
				v.found = 1'b1;
				v.idx = k[3:0];
				break;
			end
		end
		return v;
	endfunction

	function automatic sample_t make_box(logic [7:0] l0, logic [7:0] h0,
		logic [7:0] l1, logic [7:0] h1, logic [7:0] l2, logic [7:0] h2);
		sample_t s;
		s.op = MODE_APPEND;
		s.cfg = 1'b0;
		s.lo = '{l0, l1, l2};
		s.hi = '{h0, h1, h2};
		for (int c = 0; c < 3; c++) s.pulse[c] = 16'($urandom);
		return s;
	endfunction

	function automatic sample_t make_probe(logic [15:0] r, logic [15:0] g,
		logic [15:0] b);
		sample_t s;
		s.op = MODE_CLASSIFY;
		s.cfg = 1'b0;
		s.pulse = '{r, g, b};
		for (int c = 0; c < 3; c++) begin
			s.lo[c] = 8'($urandom);
			s.hi[c] = 8'($urandom);
		end
		return s;
	endfunction

	function automatic sample_t make_cal(logic [15:0] rl, logic [15:0] rh,
		logic [15:0] gl, logic [15:0] gh, logic [15:0] bl, logic [15:0] bh);
		sample_t s;
		s = make_probe(16'd0, 16'd0, 16'd0);
		s.cfg = 1'b1;
		s.cal = '{rl, rh, gl, gh, bl, bh};
		return s;
	endfunction

	// Fill the pending queue with phases of boxes, probes and calibrations
	initial begin
		logic [7:0] a, b;
		int phase;
		pending_q.push_back(make_probe(16'hFFFF, 16'h0000, 16'h8000));
		pending_q.push_back(make_box(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255));
		pending_q.push_back(make_probe(16'hFFFF, 16'hFFFF, 16'hFFFF));
		pending_q.push_back(make_cal(16'd100, 16'd100, 16'd200, 16'd100, 16'hFFFF, 16'd0));
		pending_q.push_back(make_probe(16'd100, 16'd150, 16'd0));
		pending_q.push_back(make_probe(16'd0, 16'd50, 16'hFFFF));
		pending_q.push_back(make_cal(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'hFFFF));
		pending_q.push_back(make_probe(16'hFFFF, 16'd0, 16'h7FFF));
		pending_q.push_back(make_cal(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF));
		for (int i = 0; i < 15; i++)
			pending_q.push_back(make_box(8'd200, 8'd10, 8'($urandom), 8'hFF,
				8'h55, 8'hAA));
		pending_q.push_back(make_box(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		pending_q.push_back(make_probe(16'hFFFF, 16'hFFFF, 16'hFFFF));
		pending_q.push_back(make_probe(16'h0000, 16'h0000, 16'h0000));
		while (pending_q.size() < 420) begin
			phase = $urandom_range(0, 3);
			// Reset-like refill is impossible; new boxes only land while not full
			for (int i = 0; i < 4; i++) begin
				a = 8'($urandom);
				b = 8'($urandom);
				if ($urandom_range(0, 5) != 0 && a > b) {a, b} = {b, a};
				pending_q.push_back(make_box(a, b, 8'($urandom_range(0, a)),
					8'($urandom_range(b, 255)), 8'($urandom_range(0, 128)),
					8'($urandom_range(100, 255))));
			end
			if (phase == 0)
				pending_q.push_back(make_cal(16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)));
			else if (phase == 1)
				pending_q.push_back(make_cal(16'($urandom_range(0, 2000)),
					16'($urandom_range(3000, 65535)), 16'($urandom_range(0, 2000)),
					16'($urandom_range(3000, 65535)), 16'($urandom_range(0, 2000)),
					16'($urandom_range(3000, 65535))));
			for (int i = 0; i < 20; i++)
				pending_q.push_back(make_probe(16'($urandom), 16'($urandom),
					16'($urandom)));
		end
	end

	// Hold reset low at start, then release it
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Driver: issue transactions, calibrate only once the block is drained
	always @(posedge clk) begin
		sample_t s;
		logic we_next;
		we_next = 1'b0;
		cycles <= cycles + 1;
		if (cycles == 3000) calm <= 1'b1;
		if (cycles == 12000) calm <= 1'b0;
		if (!arst_n || stim_done) begin
			start <= 1'b0;
		end else if (start && !busy) begin
			start <= 1'b0;
		end else if (!start && pending_q.size() == 0) begin
			stim_done <= 1'b1;
		end else if (!start && pending_q[0].cfg) begin
			// hold until drained, wait a scan, then write one register per cycle
			if (verdict_q.size() != 0 || busy) begin
				settle <= 0;
			end else if (settle < 60) begin
				settle <= settle + 1;
			end else begin
				we_next = 1'b1;
				cfg_index <= 3'(cfg_step);
				cfg_data <= pending_q[0].cal[cfg_step];
				cal_shadow[cfg_step] = pending_q[0].cal[cfg_step];
				if (cfg_step == NumRegs - 1) begin
					cfg_step <= 0;
					void'(pending_q.pop_front());
				end else begin
					cfg_step <= cfg_step + 1;
				end
			end
		end else if (!start && !busy && (calm || $urandom_range(0, 99) >= 19)) begin
			s = pending_q.pop_front();
			verdict_q.push_back(classify_or_append(s));
			start <= 1'b1;
			mode <= s.op;
			red_pulse <= s.pulse[0];
			green_pulse <= s.pulse[1];
			blue_pulse <= s.pulse[2];
			red_low <= s.lo[0];
			red_high <= s.hi[0];
			green_low <= s.lo[1];
			green_high <= s.hi[1];
			blue_low <= s.lo[2];
			blue_high <= s.hi[2];
		end
		cfg_we <= we_next;
	end

	initial begin
		cal_shadow = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF};
		box_total = 0;
		cfg_step = 0;
		settle = 0;
	end

	// Monitor: compare each result against the oldest expectation
	always @(posedge clk) begin
		verdict_t v;
		if (arst_n && strobe) begin
			if (verdict_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
			end else begin
				v = verdict_q.pop_front();
				if (v.found !== found || v.idx !== match_index || v.full !== table_full
					|| v.level[0] !== red_level || v.level[1] !== green_level
					|| v.level[2] !== blue_level) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp f%0b i%0d r%0d g%0d b%0d t%0b got f%0b i%0d r%0d g%0d b%0d t%0b",
							v.found, v.idx, v.level[0], v.level[1], v.level[2], v.full,
							found, match_index, red_level, green_level, blue_level,
							table_full);
				end
			end
		end
	end

	// End of run: drain, settle, report
	initial begin
		wait (stim_done && verdict_q.size() == 0 || cycles >= CycleLimit);
		if (cycles >= CycleLimit) begin
			$display("FAIL");
		end else begin
			repeat (60) @(posedge clk);
			if (mismatches == 0 && verdict_q.size() == 0) $display("PASS");
			else $display("FAIL");
		end
		$finish;
	end
endmodule
